@@ sv/thwd_pkg.sv @@
// thwd_pkg: shared types and constants for the two-level hash word dictionary
// no dependencies
package thwd_pkg;

    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 12;
    localparam int CH_W     = 8;

    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd5;

    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [0:0] REG_PRIMARY   = 1'b0;
    localparam logic [0:0] REG_SECONDARY = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       last;
    } thwd_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  word_total;
    } thwd_out_t;

endpackage

@@ sv/thwd_if.sv @@
// thwd_if: valid/ready channel carrying one payload item
// depends on nothing; payload type given as a type parameter
interface thwd_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/thwd_mod.sv @@
// thwd_mod: shared multi-cycle reducer, value mod m by restoring subtraction
// depends on thwd_pkg for nothing beyond style; one bit per cycle
module thwd_mod #(
    parameter int VW = 13,
    parameter int MW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] value,
    input  logic [MW-1:0] modulus,
    output logic          done,
    output logic [MW-1:0] result
);
    import thwd_pkg::*;

    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0] val_reg, val_next;
    logic [MW:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [MW:0]   shifted;
    logic [MW:0]   diff;

    assign shifted = {rem_reg[MW-1:0], val_reg[VW-1]};
    assign diff    = shifted - {1'b0, modulus};

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            cnt_next  = CW'(VW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[VW-2:0], 1'b0};
            rem_next = (shifted >= {1'b0, modulus}) ? diff : shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg[MW-1:0];
endmodule

@@ sv/two_level_hash_word_dictionary.sv @@
// two_level_hash_word_dictionary: top level, sequencer, stores and apb registers
// depends on thwd_pkg, thwd_if, thwd_mod
//
//  channel | dir | payload             | note
//  in_ch   | in  | cmd, ch, last       | one byte of a word per item
//  out_ch  | out | status, word_total  | one item per last byte
//  apb     | in  | primary/secondary   | 7-bit and 6-bit registers at 0x0, 0x4
//
// a non-last byte takes two passes of the shared bit-serial reducer, one for each
// level's hash; a last byte of an over-long word then goes straight to the output
// any other last byte adds two more reductions, a probe that visits one slot at a time,
// a byte-by-byte compare on each slot of equal length, on an insert a store of the
// bytes and then the length, and the S_OUT and S_WAIT states that hand the result to
// the output register; after reset a clearing pass empties the length of every slot;
// no item is accepted until it ends
// the result moves to an output register; the block waits only when a new
// result is ready while the previous one has not been taken
module two_level_hash_word_dictionary #(
    parameter int PRIMARY_DEPTH   = 64,
    parameter int SECONDARY_DEPTH = 53,
    parameter int MAX_WORD        = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    thwd_if.sink        in_ch,
    thwd_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import thwd_pkg::*;

    localparam int PW     = $clog2(PRIMARY_DEPTH + 1);
    localparam int PIW    = (PRIMARY_DEPTH > 1) ? $clog2(PRIMARY_DEPTH) : 1;
    localparam int SW     = $clog2(SECONDARY_DEPTH + 1);
    localparam int SIW    = (SECONDARY_DEPTH > 1) ? $clog2(SECONDARY_DEPTH) : 1;
    localparam int SLOTS  = PRIMARY_DEPTH * SECONDARY_DEPTH;
    localparam int SLW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW     = $clog2(MAX_WORD + 1);
    localparam int KW     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int CHARS  = SLOTS * MAX_WORD;
    localparam int CAW    = $clog2(CHARS);
    localparam int MW     = (PW > SW) ? PW : SW;
    // hash*33 + 127 fits in MW+7 bits
    localparam int VW     = MW + 7;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_HP     = 11'b00000000100,
        S_HS     = 11'b00000001000,
        S_RP     = 11'b00000010000,
        S_RS     = 11'b00000100000,
        S_LEN    = 11'b00001000000,
        S_CMP    = 11'b00010000000,
        S_WRITE  = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_WAIT   = 11'b10000000000
    } state_t;

    // ---------------- configuration registers ----------------
    logic [6:0] prim_cfg_reg;
    logic [5:0] sec_cfg_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_cfg_reg <= 7'd50;
            sec_cfg_reg  <= 6'd11;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_PRIMARY)
                prim_cfg_reg <= pwdata[6:0];
            else
                sec_cfg_reg <= pwdata[5:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PRIMARY)
            prdata[6:0] = prim_cfg_reg;
        else
            prdata[5:0] = sec_cfg_reg;
    end

    // effective moduli: zero acts as one, clamp at depth
    logic [PW-1:0] p_eff;
    logic [SW-1:0] s_eff;

    always_comb
    begin
        if (prim_cfg_reg == '0)
            p_eff = PW'(1);
        else if (32'(prim_cfg_reg) > PRIMARY_DEPTH)
            p_eff = PW'(PRIMARY_DEPTH);
        else
            p_eff = PW'(prim_cfg_reg);
        if (sec_cfg_reg == '0)
            s_eff = SW'(1);
        else if (32'(sec_cfg_reg) > SECONDARY_DEPTH)
            s_eff = SW'(SECONDARY_DEPTH);
        else
            s_eff = SW'(sec_cfg_reg);
    end

    // ---------------- state ----------------
    state_t          state_reg, state_next;
    logic [PIW-1:0]  ph_reg, ph_next;
    logic [SIW-1:0]  sh_reg, sh_next;
    logic [LW-1:0]   wlen_reg, wlen_next;
    logic            long_reg, long_next;
    logic            cmd_reg, cmd_next;
    logic            last_reg, last_next;
    logic [6:0]      letter_reg, letter_next;
    logic [TOTAL_W-1:0] count_reg, count_next;
    logic [SLW-1:0]  clr_reg, clr_next;
    logic [SIW-1:0]  idx_reg, idx_next;
    logic [SW-1:0]   probe_reg, probe_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [LW-1:0]   wk_reg, wk_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic            ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ostatus_reg, ostatus_next;
    logic [TOTAL_W-1:0]  ototal_reg, ototal_next;

    logic [7:0]      wbuf [MAX_WORD];
    logic [LW-1:0]   len_mem [SLOTS];
    logic [7:0]      char_mem [CHARS];
    logic [LW-1:0]   len_q;
    logic [7:0]      char_q;

    // shared reducer
    logic            mod_start;
    logic [VW-1:0]   mod_val;
    logic [MW-1:0]   mod_m;
    logic            mod_done;
    logic [MW-1:0]   mod_res;

    thwd_mod #(.VW(VW), .MW(MW)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .value(mod_val),
        .modulus(mod_m), .done(mod_done), .result(mod_res)
    );

    logic            in_fire;
    logic [SLW-1:0]  slot_addr;
    logic [CAW-1:0]  char_addr;
    logic            len_we;
    logic [SLW-1:0]  len_wa;
    logic [LW-1:0]   len_wd;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign slot_addr   = SLW'(32'(ph_reg) * SECONDARY_DEPTH + 32'(idx_reg));
    assign char_addr   = CAW'(32'(slot_addr) * MAX_WORD + 32'(k_reg));

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        sh_next      = sh_reg;
        wlen_next    = wlen_reg;
        long_next    = long_reg;
        cmd_next     = cmd_reg;
        last_next    = last_reg;
        letter_next  = letter_reg;
        count_next   = count_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        probe_next   = probe_reg;
        k_next       = k_reg;
        wk_next      = wk_reg;
        status_next  = status_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        ototal_next  = ototal_reg;
        mod_start    = 1'b0;
        mod_val      = '0;
        mod_m        = '0;
        len_we       = 1'b0;
        len_wa       = slot_addr;
        len_wd       = wlen_reg;
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                len_we = 1'b1;
                len_wa = clr_reg;
                len_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == SLOTS - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next    = in_ch.data.cmd;
                    last_next   = in_ch.data.last;
                    letter_next = in_ch.data.ch[7] ? 7'd0 : in_ch.data.ch[6:0];
                    if (32'(wlen_reg) < MAX_WORD)
                        wlen_next = wlen_reg + 1'b1;
                    else
                        long_next = 1'b1;
                    mod_start = 1'b1;
                    // hash*33 as a shift and an add
                    mod_val   = (VW'(ph_reg) << 5) + VW'(ph_reg)
                                + VW'(in_ch.data.ch[7] ? 7'd0 : in_ch.data.ch[6:0]);
                    mod_m     = MW'(p_eff);
                    state_next = S_HP;
                end
            end
            S_HP:
            begin
                mod_m = MW'(p_eff);
                if (mod_done)
                begin
                    ph_next   = PIW'(mod_res);
                    mod_start = 1'b1;
                    mod_val   = VW'({sh_reg, 5'b0}) - VW'(sh_reg) + VW'(letter_reg);
                    mod_m     = MW'(s_eff);
                    state_next = S_HS;
                end
            end
            S_HS:
            begin
                mod_m = MW'(s_eff);
                if (mod_done)
                begin
                    sh_next = SIW'(mod_res);
                    if (!last_reg)
                        state_next = S_IDLE;
                    else if (long_reg)
                    begin
                        status_next = ST_TOO_LONG;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        mod_val    = VW'(ph_next);
                        mod_m      = MW'(p_eff);
                        state_next = S_RP;
                    end
                end
            end
            S_RP:
            begin
                mod_m = MW'(p_eff);
                if (mod_done)
                begin
                    ph_next    = PIW'(mod_res);
                    mod_start  = 1'b1;
                    mod_val    = VW'(sh_reg);
                    mod_m      = MW'(s_eff);
                    state_next = S_RS;
                end
            end
            S_RS:
            begin
                mod_m = MW'(s_eff);
                if (mod_done)
                begin
                    idx_next     = SIW'(mod_res);
                    probe_next   = '0;
                    k_next       = '0;
                    state_next   = S_LEN;
                end
            end
            S_LEN:
            begin
                // len_q holds the length of slot idx
                if (probe_reg == s_eff)
                begin
                    status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_ABSENT;
                    state_next  = S_OUT;
                end
                else if (len_q == '0)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        k_next     = '0;
                        wk_next    = '0;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                        state_next  = S_OUT;
                    end
                end
                else if (len_q == wlen_reg)
                begin
                    k_next       = '0;
                    wk_next      = '0;
                    state_next   = S_CMP;
                end
                else
                begin
                    idx_next     = (32'(idx_reg) + 1 >= 32'(s_eff)) ? '0 : idx_reg + 1'b1;
                    probe_next   = probe_reg + 1'b1;
                    state_next   = S_LEN;
                end
            end
            S_CMP:
            begin
                // char_q holds byte wk of slot, read at the address k gave
                if (char_q != wbuf[wk_reg[KW-1:0]])
                begin
                    idx_next   = (32'(idx_reg) + 1 >= 32'(s_eff)) ? '0 : idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    k_next     = '0;
                    state_next = S_LEN;
                end
                else if (32'(wk_reg) + 1 == 32'(wlen_reg))
                begin
                    status_next = (cmd_reg == CMD_INSERT) ? ST_PRESENT : ST_FOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    wk_next = wk_reg + 1'b1;
                    k_next  = k_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                // one byte per cycle, then the length
                if (32'(wk_reg) == 32'(wlen_reg))
                begin
                    len_we = 1'b1;
                    if (count_reg != '1)
                        count_next = count_reg + 1'b1;
                    status_next = ST_INSERTED;
                    state_next  = S_OUT;
                end
                else
                begin
                    wk_next = wk_reg + 1'b1;
                    k_next  = k_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                // load the output register once the previous item leaves
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    ototal_next  = count_reg;
                    wlen_next    = '0;
                    long_next    = 1'b0;
                    ph_next      = '0;
                    sh_next      = '0;
                    state_next   = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ph_reg      <= '0;
            sh_reg      <= '0;
            wlen_reg    <= '0;
            long_reg    <= 1'b0;
            count_reg   <= '0;
            clr_reg     <= '0;
            ovalid_reg  <= 1'b0;
            ostatus_reg <= '0;
            ototal_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            sh_reg      <= sh_next;
            wlen_reg    <= wlen_next;
            long_reg    <= long_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            ovalid_reg  <= ovalid_next;
            ostatus_reg <= ostatus_next;
            ototal_reg  <= ototal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        last_reg   <= last_next;
        letter_reg <= letter_next;
        idx_reg    <= idx_next;
        probe_reg  <= probe_next;
        k_reg      <= k_next;
        wk_reg     <= wk_next;
        status_reg <= status_next;
        if (in_fire && 32'(wlen_reg) < MAX_WORD)
            wbuf[wlen_reg[KW-1:0]] <= in_ch.data.ch;
    end

    // length memory: one write port, read at the next slot address
    logic [SLW-1:0] len_ra;
    assign len_ra = SLW'(32'(ph_next) * SECONDARY_DEPTH + 32'(idx_next));

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_wa] <= len_wd;
        len_q <= len_mem[len_ra];
    end

    // char memory: written during insert, read at the next byte address while comparing
    logic [CAW-1:0] char_ra;
    assign char_ra = CAW'(32'(len_ra) * MAX_WORD + 32'(k_next));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && 32'(wk_reg) < 32'(wlen_reg))
            char_mem[char_addr] <= wbuf[wk_reg[KW-1:0]];
        char_q <= char_mem[char_ra];
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.data.status     = ostatus_reg;
    assign out_ch.data.word_total = ototal_reg;

    // ---------------- checks ----------------
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready)
        else $error("input ready outside idle");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("word total moved by more than one");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wlen_reg) <= MAX_WORD)
        else $error("word length beyond limit");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(ostatus_reg)
        && $stable(ototal_reg))
        else $error("result dropped while stalled");
endmodule
